// ===== hw/rtl/aligned_power_of_two_range_splitter_macros.svh =====
// ----------------------------------------------------------------------------
// Range splitter assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_POWER_OF_TWO_RANGE_SPLITTER_MACROS_SVH
`define ALIGNED_POWER_OF_TWO_RANGE_SPLITTER_MACROS_SVH

// property holds at every edge out of reset
`define ASPLIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition never seen out of reset
`define ASPLIT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/asplit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range splitter package
// Shared widths, result codes and job / result records.
// ----------------------------------------------------------------------------
package asplit_pkg;

  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned IN_SIZE_W    = 28;
  localparam int unsigned SIZE_W       = 29;
  localparam int unsigned ORDER_W      = 5;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = 1;
  localparam int unsigned QCNT_W       = 2;
  localparam int unsigned S_TDATA_W    = 128;
  localparam int unsigned M_TDATA_W    = 104;
  localparam int unsigned M_TUSER_W    = 2;

  typedef enum logic [1:0] {
    ST_CHUNK      = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  typedef struct packed {
    status_e             kind;
    logic [ADDR_W-1:0]   phys;
    logic [ADDR_W-1:0]   virt;
    logic [SIZE_W-1:0]   size;
    logic                cached;
  } job_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   phys;
    logic [ADDR_W-1:0]   virt;
    logic [ORDER_W-1:0]  order;
    logic                cached;
    logic                last;
  } result_t;

  function automatic logic [ADDR_W-1:0] addr_mask(input int unsigned bits);
    logic [ADDR_W-1:0] m;
    m = '1;
    if (bits < ADDR_W) begin
      m = m >> (ADDR_W - bits);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/asplit_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range splitter front end
// Accept requests, check page alignment, saturate the size and register a job.
// ----------------------------------------------------------------------------
module asplit_front #(
  parameter int unsigned PAGE_BITS  = 12,
  parameter int unsigned ADDR_BITS  = 48,
  parameter int unsigned SIZE_BITS  = 27
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic [asplit_pkg::ADDR_W-1:0]       phys_i,
  input  logic [asplit_pkg::ADDR_W-1:0]       virt_i,
  input  logic [asplit_pkg::IN_SIZE_W-1:0]    count_i,
  input  logic                                cached_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output asplit_pkg::job_t                    job_o
);

  localparam logic [asplit_pkg::ADDR_W-1:0] AddrMask = asplit_pkg::addr_mask(ADDR_BITS);
  localparam logic [asplit_pkg::SIZE_W-1:0] SizeLimit =
    (asplit_pkg::SIZE_W'(1) << SIZE_BITS) &
    ~((asplit_pkg::SIZE_W'(1) << PAGE_BITS) - asplit_pkg::SIZE_W'(1));

  logic                            valid_q, valid_d;
  asplit_pkg::job_t                job_q, job_d;
  logic [asplit_pkg::ADDR_W-1:0]   phys_m, virt_m;
  logic [asplit_pkg::SIZE_W-1:0]   size_ext, size_sat;
  logic                            misaligned;
  logic                            accept;

  assign req_ready_o = !valid_q || job_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_comb begin
    phys_m     = phys_i & AddrMask;
    virt_m     = virt_i & AddrMask;
    size_ext   = asplit_pkg::SIZE_W'(count_i);
    misaligned = (|phys_m[PAGE_BITS-1:0]) || (|virt_m[PAGE_BITS-1:0]) ||
                 (|count_i[PAGE_BITS-1:0]);
    size_sat   = (size_ext > SizeLimit) ? SizeLimit : size_ext;

    job_d.phys   = phys_m;
    job_d.virt   = virt_m;
    job_d.size   = size_sat;
    job_d.cached = cached_i;
    if (misaligned) begin
      job_d.kind = asplit_pkg::ST_MISALIGNED;
    end else if (size_sat == '0) begin
      job_d.kind = asplit_pkg::ST_EMPTY;
    end else begin
      job_d.kind = asplit_pkg::ST_CHUNK;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

// ===== hw/rtl/asplit_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range splitter job queue
// Two-entry queue of classified jobs between front end and chunk engine.
// ----------------------------------------------------------------------------
module asplit_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  asplit_pkg::job_t  push_job_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output asplit_pkg::job_t  pop_job_o
);

  asplit_pkg::job_t                  mem_q [asplit_pkg::QUEUE_DEPTH];
  logic [asplit_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [asplit_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [asplit_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                              push, pop;

  assign push_ready_o = cnt_q != asplit_pkg::QCNT_W'(asplit_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== hw/rtl/asplit_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range splitter chunk engine
// Cut the current job into aligned power-of-two chunks, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "aligned_power_of_two_range_splitter_macros.svh"

module asplit_back #(
  parameter int unsigned PAGE_BITS  = 12,
  parameter int unsigned MAX_ORDER  = 22,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  asplit_pkg::job_t     job_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output asplit_pkg::result_t  res_o
);

  localparam logic [asplit_pkg::ADDR_W-1:0] AddrMask = asplit_pkg::addr_mask(ADDR_BITS);
  localparam logic [asplit_pkg::ORDER_W-1:0] OrderLo = asplit_pkg::ORDER_W'(PAGE_BITS);
  localparam logic [asplit_pkg::ORDER_W-1:0] OrderHi = asplit_pkg::ORDER_W'(MAX_ORDER);
  localparam logic [asplit_pkg::CNT_W-1:0]   CntLast =
    asplit_pkg::CNT_W'(asplit_pkg::RESULT_LIMIT - 1);

  logic                             busy_q, busy_d;
  logic                             out_valid_q, out_valid_d;
  asplit_pkg::job_t                 cur_q, cur_d;
  logic [asplit_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  asplit_pkg::result_t              out_q, out_d;
  logic                             load, step;
  logic [asplit_pkg::ORDER_W-1:0]   order;
  logic [asplit_pkg::SIZE_W-1:0]    chunk_size, size_rem;
  logic [asplit_pkg::ADDR_W-1:0]    chunk_addr;
  logic                             last;
  logic                             res_chunk;
  logic [asplit_pkg::ADDR_W-1:0]    out_low;

  assign job_ready_o = !busy_q;
  assign load        = job_valid_i && !busy_q;
  assign step        = busy_q && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign res_chunk   = out_valid_q && out_q.status == asplit_pkg::ST_CHUNK;
  assign out_low     = out_q.phys & ~({asplit_pkg::ADDR_W{1'b1}} << out_q.order);

  always_comb begin
    logic ok;
    ok    = 1'b1;
    order = OrderLo;
    for (int o = PAGE_BITS + 1; o <= MAX_ORDER; o++) begin
      ok = ok && !cur_q.phys[o-1] && ((cur_q.size >> o) != '0);
      if (ok) begin
        order = asplit_pkg::ORDER_W'(o);
      end
    end
    chunk_size = asplit_pkg::SIZE_W'(1) << order;
    chunk_addr = asplit_pkg::ADDR_W'(1) << order;
    size_rem   = cur_q.size - chunk_size;
    last       = (size_rem == '0) || (cnt_q == CntLast);
  end

  always_comb begin
    busy_d      = busy_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      cur_d  = job_i;
      cnt_d  = '0;
    end else if (step) begin
      out_valid_d = 1'b1;
      if (cur_q.kind != asplit_pkg::ST_CHUNK) begin
        out_d        = '0;
        out_d.status = cur_q.kind;
        out_d.last   = 1'b1;
        busy_d       = 1'b0;
      end else begin
        out_d.status = asplit_pkg::ST_CHUNK;
        out_d.phys   = cur_q.phys;
        out_d.virt   = cur_q.virt;
        out_d.order  = order;
        out_d.cached = cur_q.cached;
        out_d.last   = last;
        cur_d.size   = size_rem;
        cur_d.phys   = (cur_q.phys + chunk_addr) & AddrMask;
        cur_d.virt   = (cur_q.virt + chunk_addr) & AddrMask;
        cnt_d        = cnt_q + 1'b1;
        busy_d       = !last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  `ASPLIT_ASSERT(a_order_range, res_chunk |-> out_q.order >= OrderLo && out_q.order <= OrderHi, "bad order")
  `ASPLIT_ASSERT(a_chunk_aligned, res_chunk |-> out_low == '0, "chunk not aligned to its order")
  `ASPLIT_ASSERT_NEVER(a_error_not_last, out_valid_q && out_q.status != asplit_pkg::ST_CHUNK && !out_q.last, "error result not marked last")

endmodule

// ===== hw/rtl/aligned_power_of_two_range_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned power-of-two range splitter
// Split a page-aligned mapping request into naturally aligned chunks.
// ----------------------------------------------------------------------------
// Input channel s_axis: one mapping request per item (addresses, size, cache
// flag). Output channel m_axis: one result per item; tuser gives the status
// (chunk, misaligned, empty), tlast marks the final result of a request.
// The first result of a request passes in order through the front register,
// the job queue, the engine's job load and the engine's output register.
// The chunk engine emits one result per cycle while m_axis does not stall,
// and it loads each job before that job's first result; a request gives 1
// to 64 results. A two-entry job queue and the front register let up to
// three further requests be taken while the engine works.
// Reset clears all valid state; no request or result survives it.
// A stall on m_axis holds the current result; the engine and then the queue
// and front end fill up and s_axis_tready_o falls.
// ----------------------------------------------------------------------------
module aligned_power_of_two_range_splitter #(
  parameter int unsigned PAGE_BITS  = 12,
  parameter int unsigned MAX_ORDER  = 22,
  parameter int unsigned ADDR_BITS  = 48,
  parameter int unsigned SIZE_BITS  = 27
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // phys_addr[47:0], virt_addr[95:48], byte_count[123:96], cache_mode[124]
  input  logic [asplit_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // chunk_phys[47:0], chunk_virt[95:48], chunk_order[100:96], chunk_cached[101]
  output logic [asplit_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // status[1:0]
  output logic [asplit_pkg::M_TUSER_W-1:0]    m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);

  logic                 fr_valid, fr_ready;
  asplit_pkg::job_t     fr_job;
  logic                 q_valid, q_ready;
  asplit_pkg::job_t     q_job;
  asplit_pkg::result_t  res;

  asplit_front #(
    .PAGE_BITS  (PAGE_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .phys_i      (s_axis_tdata_i[47:0]),
    .virt_i      (s_axis_tdata_i[95:48]),
    .count_i     (s_axis_tdata_i[123:96]),
    .cached_i    (s_axis_tdata_i[124]),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  asplit_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_job_i   (fr_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_job_o    (q_job)
  );

  asplit_back #(
    .PAGE_BITS  (PAGE_BITS),
    .MAX_ORDER  (MAX_ORDER),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {2'b00, res.cached, res.order, res.virt, res.phys};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

endmodule
